// ----- rtl/fpln_pkg.sv -----
// Shared types and constants for the fixed-point natural log pipeline.
package fpln_pkg;

    localparam int IN_W       = 40;
    localparam int MAG_W      = IN_W - 1;
    localparam int POS_W      = 6;
    localparam int OUT_W      = 21;
    localparam int Q_W        = 16;
    localparam int SCALE_W    = 7;
    localparam int FRAC_BITS  = 15;
    localparam int RECIP_W    = 21;
    localparam int RECIP_SH   = 20;
    localparam int MAX_DIV    = 13;

    localparam logic [POS_W-1:0]         SCALE_BIAS    = 6'd23;
    localparam logic signed [OUT_W-1:0]  LN2_Q15       = 21'sd22713;
    localparam logic signed [OUT_W-1:0]  NONPOS_RESULT = -21'sd327680;
    localparam logic [Q_W-1:0]           ONE_Q15       = 16'h8000;

    // ceil(2^20 / d): floor(p * r >> 20) == floor(p / d) for p <= 32768, d <= 13
    localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_DIV+1] = '{
        21'd0,      21'd1048576, 21'd524288, 21'd349526, 21'd262144,
        21'd209716, 21'd174763,  21'd149797, 21'd131072, 21'd116509,
        21'd104858, 21'd95326,   21'd87382,  21'd80660
    };

    typedef struct packed {
        logic                     valid;
        logic                     nonpos;
        logic [Q_W-1:0]           x;
        logic [Q_W-1:0]           power;
        logic signed [OUT_W-1:0]  sum;
    } stage_t;

endpackage

// ----- rtl/fpln_norm.sv -----
// Three-stage front end: leading-one search, mantissa shift, ln2 scaling.
module fpln_norm
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [fpln_pkg::IN_W-1:0] x_q23,
    output fpln_pkg::stage_t              stage_out
);

    // stage 1: leading-one position
    logic [fpln_pkg::POS_W-1:0]  lead_pos;
    logic                        valid1_reg;
    logic                        nonpos1_reg;
    logic [fpln_pkg::MAG_W-1:0]  mag1_reg;
    logic [fpln_pkg::POS_W-1:0]  pos1_reg;

    // stage 2: mantissa and scale
    logic [fpln_pkg::MAG_W-1:0]    shr;
    logic [fpln_pkg::MAG_W-1:0]    shl;
    logic [fpln_pkg::MAG_W-1:0]    shr_guard;
    logic [fpln_pkg::Q_W-1:0]      mant;
    logic                          special;
    logic [fpln_pkg::Q_W-1:0]      x_next;
    logic signed [fpln_pkg::SCALE_W-1:0] scale_next;
    logic                          valid2_reg;
    logic                          nonpos2_reg;
    logic [fpln_pkg::Q_W-1:0]      x2_reg;
    logic signed [fpln_pkg::SCALE_W-1:0] scale2_reg;

    // stage 3: scale times ln2
    logic                          valid3_reg;
    logic                          nonpos3_reg;
    logic [fpln_pkg::Q_W-1:0]      x3_reg;
    logic signed [fpln_pkg::OUT_W-1:0] base3_reg;

    always_comb
    begin
        lead_pos = '0;
        for (int i = 0; i < fpln_pkg::MAG_W; i++)
        begin
            if (x_q23[i])
            begin
                lead_pos = fpln_pkg::POS_W'(i);
            end
        end
    end

    always_comb
    begin
        shr       = mag1_reg >> (pos1_reg - 6'd15);
        shl       = mag1_reg << (6'd15 - pos1_reg);
        shr_guard = mag1_reg >> (pos1_reg - 6'd16);
        mant      = (pos1_reg >= 6'd15) ? shr[fpln_pkg::Q_W-1:0] : shl[fpln_pkg::Q_W-1:0];
        // mantissa is exactly 2.0 when the 16 bits below the leading one are clear
        special   = (pos1_reg >= 6'd16) && (mant == fpln_pkg::ONE_Q15) && !shr_guard[0];
        x_next    = special ? fpln_pkg::ONE_Q15 : {1'b0, mant[fpln_pkg::Q_W-2:0]};
        scale_next = fpln_pkg::SCALE_W'(pos1_reg) - fpln_pkg::SCALE_W'(fpln_pkg::SCALE_BIAS)
                   - fpln_pkg::SCALE_W'(special);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= start;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        nonpos1_reg <= x_q23[fpln_pkg::IN_W-1] || (x_q23 == '0);
        mag1_reg    <= x_q23[fpln_pkg::MAG_W-1:0];
        pos1_reg    <= lead_pos;

        nonpos2_reg <= nonpos1_reg;
        x2_reg      <= x_next;
        scale2_reg  <= scale_next;

        nonpos3_reg <= nonpos2_reg;
        x3_reg      <= x2_reg;
        base3_reg   <= fpln_pkg::OUT_W'(scale2_reg) * fpln_pkg::LN2_Q15;
    end

    assign stage_out.valid  = valid3_reg;
    assign stage_out.nonpos = nonpos3_reg;
    assign stage_out.x      = x3_reg;
    assign stage_out.power  = x3_reg;
    assign stage_out.sum    = base3_reg;

endmodule

// ----- rtl/fpln_term.sv -----
// One series stage: raise the power by x and fold in the previous power divided by DIV.
module fpln_term
#(
    parameter int DIV = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fpln_pkg::stage_t  stage_in,
    output fpln_pkg::stage_t  stage_out
);

    localparam logic [fpln_pkg::RECIP_W-1:0] RECIP = fpln_pkg::RECIP_TABLE[DIV];
    localparam bit SUBTRACT = ((DIV % 2) == 0);
    localparam int SQ_W = 2 * fpln_pkg::Q_W;
    localparam int QP_W = fpln_pkg::Q_W + fpln_pkg::RECIP_W;

    logic [SQ_W-1:0]                   sq;
    logic [QP_W-1:0]                   qprod;
    logic [fpln_pkg::Q_W-1:0]          quot;
    logic signed [fpln_pkg::OUT_W-1:0] term;
    logic                              valid_reg;
    logic                              nonpos_reg;
    logic [fpln_pkg::Q_W-1:0]          x_reg;
    logic [fpln_pkg::Q_W-1:0]          power_reg;
    logic signed [fpln_pkg::OUT_W-1:0] sum_reg;
    logic signed [fpln_pkg::OUT_W-1:0] sum_next;

    always_comb
    begin
        sq       = SQ_W'(stage_in.power) * SQ_W'(stage_in.x);
        qprod    = QP_W'(stage_in.power) * QP_W'(RECIP);
        quot     = qprod[fpln_pkg::RECIP_SH +: fpln_pkg::Q_W];
        term     = $signed({{(fpln_pkg::OUT_W-fpln_pkg::Q_W){1'b0}}, quot});
        sum_next = SUBTRACT ? (stage_in.sum - term) : (stage_in.sum + term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        nonpos_reg <= stage_in.nonpos;
        x_reg      <= stage_in.x;
        power_reg  <= sq[fpln_pkg::FRAC_BITS +: fpln_pkg::Q_W];
        sum_reg    <= sum_next;
    end

    assign stage_out.valid  = valid_reg;
    assign stage_out.nonpos = nonpos_reg;
    assign stage_out.x      = x_reg;
    assign stage_out.power  = power_reg;
    assign stage_out.sum    = sum_reg;

endmodule

// ----- rtl/fixed_point_natural_log.sv -----
// Throughput: one transaction per cycle; busy is held low since every stage advances each cycle.
// The depth is set by three normalization stages, one stage per series term, one output stage.
// The receiver cannot stall, so results leave on done and are never held.
// Reset (rst_n, async, active low) drops all in-flight transactions; data is not reset.
module fixed_point_natural_log
#(
    parameter int SERIES_TERMS = 5
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [fpln_pkg::IN_W-1:0]  x_q23,
    output logic                              done,
    output logic signed [fpln_pkg::OUT_W-1:0] ln_q15
);

    // Last divisor folds the highest power into the sum in the output stage.
    localparam int LAST_DIV = SERIES_TERMS + 1;
    localparam logic [fpln_pkg::RECIP_W-1:0] LAST_RECIP = fpln_pkg::RECIP_TABLE[LAST_DIV];
    localparam bit LAST_SUB = ((LAST_DIV % 2) == 0);
    localparam int QP_W = fpln_pkg::Q_W + fpln_pkg::RECIP_W;

    // chain[0] leaves the normalizer; chain[k] leaves series stage k.
    fpln_pkg::stage_t chain [SERIES_TERMS+1];

    logic [QP_W-1:0]                   last_qprod;
    logic [fpln_pkg::Q_W-1:0]          last_quot;
    logic signed [fpln_pkg::OUT_W-1:0] last_term;
    logic signed [fpln_pkg::OUT_W-1:0] sum_final;
    logic signed [fpln_pkg::OUT_W-1:0] ln_next;
    logic                              done_reg;
    logic signed [fpln_pkg::OUT_W-1:0] ln_reg;

    // Every stage advances each cycle, so a new transaction is always taken.
    assign busy = 1'b0;

    // Find the leading one, shift the mantissa into [1.0, 2.0], and turn the
    // shift count into a multiple of ln2 that seeds the running sum.
    fpln_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start && !busy),
        .x_q23     (x_q23),
        .stage_out (chain[0])
    );

    // Stage k adds x^k / k with alternating sign and forms x^(k+1).
    for (genvar k = 1; k <= SERIES_TERMS; k++)
    begin : g_term
        fpln_term
        #(
            .DIV (k)
        )
        u_term
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[k-1]),
            .stage_out (chain[k])
        );
    end

    // Output stage: fold in the last power, then pick the fixed answer for a
    // zero or negative operand.
    always_comb
    begin
        last_qprod = QP_W'(chain[SERIES_TERMS].power) * QP_W'(LAST_RECIP);
        last_quot  = last_qprod[fpln_pkg::RECIP_SH +: fpln_pkg::Q_W];
        last_term  = $signed({{(fpln_pkg::OUT_W-fpln_pkg::Q_W){1'b0}}, last_quot});
        sum_final  = LAST_SUB ? (chain[SERIES_TERMS].sum - last_term)
                              : (chain[SERIES_TERMS].sum + last_term);
        ln_next    = chain[SERIES_TERMS].nonpos ? fpln_pkg::NONPOS_RESULT : sum_final;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain[SERIES_TERMS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ln_reg <= ln_next;
    end

    assign done   = done_reg;
    assign ln_q15 = ln_reg;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the fixed-point natural log pipeline.
module testbench;

    // Number of series terms after x; the predictor and the instance share it.
    localparam int N_TERMS    = 5;
    // Start-to-done latency of the block.
    localparam int LATENCY    = N_TERMS + 4;
    // Generous end-of-run limit in clock cycles.
    localparam int CYCLE_LIMIT = 400000;
    localparam longint TWO_Q15_VAL = 65536;

    typedef struct {
        logic signed [fpln_pkg::IN_W-1:0]  operand;
        logic signed [fpln_pkg::OUT_W-1:0] ln_value;
    } ln_expect_t;

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    logic signed [fpln_pkg::IN_W-1:0]   x_q23;
    logic                               done;
    logic signed [fpln_pkg::OUT_W-1:0]  ln_q15;

    // Expected log values in order of acceptance.
    ln_expect_t ln_expected[$];

    int errors      = 0;
    int cycles      = 0;
    int n_sent      = 0;
    int n_positive  = 0;
    int n_nonpos    = 0;
    int n_checked   = 0;

    fixed_point_natural_log #(
        .SERIES_TERMS (N_TERMS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .x_q23  (x_q23),
        .done   (done),
        .ln_q15 (ln_q15)
    );

    // 10-unit clock period.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predict the Q15 natural log of a Q23 operand.
    // Normalize the operand into [1.0, 2.0] in Q15, counting halvings from a
    // bias of -8 (Q23 to Q15), then sum the alternating series on x = m - 1.
    function automatic logic signed [fpln_pkg::OUT_W-1:0] predict_ln(
        logic signed [fpln_pkg::IN_W-1:0] operand);
        longint unsigned mant;
        longint          halvings;
        longint          xfrac;
        longint          power;
        longint          acc;
        longint          term;
        if (operand <= 0)
            return fpln_pkg::NONPOS_RESULT;
        mant     = longint'(operand);
        halvings = -8;
        // Keep a mantissa of exactly 2.0 as is: x becomes 1.0.
        while (mant > TWO_Q15_VAL)
        begin
            mant = mant >> 1;
            halvings++;
        end
        while (mant < longint'(fpln_pkg::ONE_Q15))
        begin
            mant = mant << 1;
            halvings--;
        end
        xfrac = longint'(mant) - longint'(fpln_pkg::ONE_Q15);
        acc   = xfrac;
        power = xfrac;
        for (int i = 0; i < N_TERMS; i++)
        begin
            // Products are non-negative, so the shift is a floor.
            power = (power * xfrac) >>> fpln_pkg::FRAC_BITS;
            term  = power / (i + 2);
            if ((i % 2) == 0)
                acc = acc - term;
            else
                acc = acc + term;
        end
        acc = acc + halvings * longint'(fpln_pkg::LN2_Q15);
        return acc[fpln_pkg::OUT_W-1:0];
    endfunction

    // Record each accepted transaction and check each result strobe.
    // Inputs are driven by nonblocking assignment at the edge, so the values
    // seen here are the ones the block samples at this same edge.
    always @(posedge clk)
    begin
        ln_expect_t exp_item;
        ln_expect_t got_item;
        if (rst_n)
        begin
            if (done)
            begin
                if (ln_expected.size() == 0)
                begin
                    $display("%0t: unexpected result ln_q15=%0d with nothing pending",
                             $time, ln_q15);
                    errors++;
                end
                else
                begin
                    got_item = ln_expected.pop_front();
                    n_checked++;
                    if (ln_q15 !== got_item.ln_value)
                    begin
                        $display("%0t: ln_q15 mismatch for x_q23=%0d: expected %0d, actual %0d",
                                 $time, got_item.operand, got_item.ln_value, ln_q15);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                exp_item.operand  = x_q23;
                exp_item.ln_value = predict_ln(x_q23);
                ln_expected.push_back(exp_item);
                n_sent++;
                if (x_q23 > 0)
                    n_positive++;
                else
                    n_nonpos++;
            end
        end
    end

    // Bound the run; a hang ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     ln_expected.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one transaction and hold it until accepted.
    // Check busy at the falling edge, where it is stable, then advance to the
    // accepting rising edge. Leave start high; the gap task lowers it.
    task automatic send_operand(input logic signed [fpln_pkg::IN_W-1:0] operand);
        start <= 1'b1;
        x_q23 <= operand;
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
    endtask

    // Lower start and idle for the requested gap; an n of zero leaves start as is.
    task automatic idle_cycles(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Mostly no gap, sometimes a short one, rarely a long one.
    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            idle_cycles(0);
        else if (r < 92)
            idle_cycles($urandom_range(1, 3));
        else
            idle_cycles($urandom_range(8, 40));
    endtask

    // Hold off the sender until every pending result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (ln_expected.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [fpln_pkg::IN_W-1:0] rand_full();
        logic [fpln_pkg::IN_W-1:0] v;
        v[fpln_pkg::IN_W-1:32] = 8'($urandom_range(0, 255));
        v[31:0]                = $urandom();
        return v;
    endfunction

    // Positive operand with a random leading-one position.
    function automatic logic signed [fpln_pkg::IN_W-1:0] rand_positive();
        logic [fpln_pkg::IN_W-1:0] v;
        int                        msb;
        msb    = $urandom_range(0, fpln_pkg::IN_W - 2);
        v      = rand_full() & ((40'd1 << msb) - 40'd1);
        v[msb] = 1'b1;
        return v;
    endfunction

    // Operand whose mantissa lands on or next to 2.0 after normalization.
    function automatic logic signed [fpln_pkg::IN_W-1:0] rand_near_two();
        logic [fpln_pkg::IN_W-1:0] v;
        int                        k;
        k = $urandom_range(0, 23);
        v = 40'd65536 << k;
        if ($urandom_range(0, 1) == 1)
            v = v + 40'($urandom_range(0, 6)) - 40'd3;
        return v;
    endfunction

    // Extremes of the operand field and the non-positive cases.
    task automatic test_operand_extremes();
        send_operand(40'sd0);
        send_operand(-40'sd1);
        send_operand({1'b1, {(fpln_pkg::IN_W-1){1'b0}}});
        send_operand({1'b0, {(fpln_pkg::IN_W-1){1'b1}}});
        send_operand(40'sd1);
        send_operand(40'sd2);
        send_operand(40'sh40_0000_0000);
        idle_cycles(2);
        send_operand(-40'sd8388608);
        send_operand(40'sh55_5555_5555);
        send_operand(40'sh2A_AAAA_AAAA);
        drain_results();
    endtask

    // Normalization boundaries, including a mantissa of exactly 2.0.
    task automatic test_mantissa_edges();
        send_operand(40'sd8388608);       // 1.0: log zero
        send_operand(40'sd16777216);      // 2.0
        send_operand(40'sd32768);
        send_operand(40'sd32767);
        send_operand(40'sd65535);
        send_operand(40'sd65536);         // stays at 2.0
        send_operand(40'sd65537);
        send_operand(40'sd131072);        // halves down to exactly 2.0
        send_operand(40'sd131073);
        send_operand(40'sd8388607);
        send_operand(40'sd12582912);      // 1.5
        send_operand(40'sd70000);
        drain_results();
    endtask

    // Random mix of operand classes with random start gaps.
    task automatic test_random_mix(input int n_items);
        int                                 pick;
        logic signed [fpln_pkg::IN_W-1:0]   operand;
        for (int i = 0; i < n_items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                operand = rand_positive();
            else if (pick < 55)
                operand = rand_full();
            else if (pick < 70)
                operand = rand_near_two();
            else if (pick < 80)
                operand = 40'sd1 << $urandom_range(0, fpln_pkg::IN_W - 2);
            else if (pick < 90)
                operand = rand_full() | {1'b1, {(fpln_pkg::IN_W-1){1'b0}}};
            else if (pick < 95)
                operand = 40'sd0;
            else
                operand = 40'($urandom_range(1, 70000));
            send_operand(operand);
            random_gap();
            // Pause the sender now and then until the pipeline is empty.
            if ((i % 400) == 399)
                drain_results();
        end
    endtask

    // Full-rate stream with no gaps at all.
    task automatic test_back_to_back(input int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 1) == 1)
                send_operand(rand_positive());
            else
                send_operand(rand_full());
        end
        idle_cycles(1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        x_q23 = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_operand_extremes();
        test_mantissa_edges();
        test_back_to_back(150);
        test_random_mix(1150);

        // Wait for the last result, then let the pipeline settle.
        drain_results();
        repeat (LATENCY + 4) @(posedge clk);

        $display("sent %0d operands (%0d positive, %0d zero or negative), checked %0d results",
                 n_sent, n_positive, n_nonpos, n_checked);
        $display("covered field extremes, mantissa edges, full-rate and gapped streams");
        if (errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/fpln_pkg.sv
rtl/fpln_norm.sv
rtl/fpln_term.sv
rtl/fixed_point_natural_log.sv
verif/testbench.sv
